>>> rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_HOLDS(label, !(expr), msg)

`endif

>>> rtl/caci_pkg.sv
// shared types and constants of the charge integrator
`timescale 1ns / 1ps
`default_nettype none

package caci_pkg;

    localparam int unsigned DVD_W  = 32;
    localparam int unsigned DSR_W  = 19;
    localparam int unsigned STEP_W = 6;

    localparam logic [9:0]        MAX_WINDOW_TICKS = 10'd1000;
    localparam logic [9:0]        MIN_WINDOW_TICKS = 10'd1;
    localparam logic [9:0]        RECIP_NUMERATOR  = 10'd1000;
    localparam logic [DSR_W-1:0]  CHARGE_SCALE     = 19'd360;
    localparam logic [STEP_W-1:0] STEPS_FULL       = 6'd32;
    localparam logic [STEP_W-1:0] STEPS_RECIP      = 6'd10;

    localparam logic [9:0] TPR_RESET  = 10'd100;
    localparam logic [7:0] BIAS_RESET = 8'sd5;

    typedef enum logic [0:0] {
        CFG_TICKS_PER_REPORT = 1'b0,
        CFG_SAMPLE_BIAS      = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> rtl/caci_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module caci_sdiv
    import caci_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DSR_W-1:0] i_divisor,
    output t_div_stat             o_stat,
    output logic      [DVD_W-1:0] o_quotient
);

    logic [DSR_W:0]    r_rem;
    logic [DVD_W-1:0]  r_dvd;
    logic [DVD_W-1:0]  r_quo;
    logic [DSR_W-1:0]  r_dsr;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DSR_W:0] w_shift;
    logic           w_ge;

    assign w_shift = {r_rem[DSR_W-1:0], r_dvd[DVD_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dsr});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == STEP_W'(1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_quo <= '0;
            r_dsr <= i_divisor;
            r_cnt <= i_ctl.steps;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_shift - {1'b0, r_dsr}) : w_shift;
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
            r_cnt <= r_cnt - STEP_W'(1);
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

`default_nettype wire

>>> rtl/current_average_charge_integrator.sv
// top level of the current averaging and charge integration block
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// One beat per tick. A plain tick adds sample plus bias into the window sum
// through a one-bit serial adder, and the next beat waits until the add is
// done. A tick that closes a report window then runs three divisions on one
// shared bit-serial divider (1000 by the window length, window sum by sample
// count, charge total by the scale), one quotient bit per cycle. A finished
// result waits in the output register while the next beat is accepted; a clear
// beat zeroes the elapsed time and charge total and leaves the block idle.

module current_average_charge_integrator
    import caci_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [9:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic signed [15:0] i_current_sample,
    input  wire logic        i_clear_totals,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_elapsed_ms,
    output logic signed [16:0] o_average_current,
    output logic signed [31:0] o_charge_hundredths_mah
);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b0000000001,
        ST_ADD    = 10'b0000000010,
        ST_RECIP  = 10'b0000000100,
        ST_RECIPW = 10'b0000001000,
        ST_AVG    = 10'b0000010000,
        ST_AVGW   = 10'b0000100000,
        ST_CHG    = 10'b0001000000,
        ST_CDIV   = 10'b0010000000,
        ST_CDIVW  = 10'b0100000000,
        ST_EMIT   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    logic [9:0]        r_tpr;
    logic signed [7:0] r_bias;
    logic [9:0]        r_win_ticks;
    logic [9:0]        r_count;
    logic [31:0]       r_elapsed;
    logic [31:0]       r_win_sum;
    logic signed [31:0] r_charge;
    logic              r_due;
    logic [15:0]       r_ser_smp;
    logic [7:0]        r_ser_bias;
    logic [1:0]        r_carry;
    logic [4:0]        r_bit;
    logic [DSR_W-1:0]  r_scale;
    logic              r_avg_neg;
    logic              r_chg_neg;
    logic signed [32:0] r_avg;

    logic              r_out_valid;
    logic [31:0]       r_out_elapsed;
    logic [16:0]       r_out_avg;
    logic [31:0]       r_out_chg;

    logic [9:0]        w_eff_win;
    logic              w_accept;
    logic [9:0]        w_next_ticks;
    logic              w_next_due;
    logic [2:0]        w_bitsum;
    logic signed [33:0] w_tot;
    logic [31:0]       w_tot_sat;
    logic              w_out_free;
    logic [DVD_W-1:0]  w_quo;

    t_div_ctl          w_div_ctl;
    t_div_stat         w_div_stat;
    logic [DVD_W-1:0]  w_dividend;
    logic [DSR_W-1:0]  w_divisor;

    caci_sdiv u_sdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_stat     (w_div_stat),
        .o_quotient (w_quo)
    );

    // window length limited to the supported range
    always_comb begin
        if (r_tpr == '0) begin
            w_eff_win = MIN_WINDOW_TICKS;
        end else if (r_tpr > MAX_WINDOW_TICKS) begin
            w_eff_win = MAX_WINDOW_TICKS;
        end else begin
            w_eff_win = r_tpr;
        end
    end

    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_next_ticks = r_win_ticks + 10'd1;
    assign w_next_due   = (w_next_ticks >= w_eff_win);
    assign w_out_free   = !r_out_valid || !i_out_stall;

    assign w_bitsum = {2'b0, r_win_sum[0]} + {2'b0, r_ser_smp[0]}
                    + {2'b0, r_ser_bias[0]} + {1'b0, r_carry};

    assign w_tot = {{2{r_charge[31]}}, r_charge} + {r_avg[32], r_avg};

    always_comb begin
        if (w_tot[33:31] == 3'b000 || w_tot[33:31] == 3'b111) begin
            w_tot_sat = w_tot[31:0];
        end else begin
            w_tot_sat = w_tot[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // divider launch and operand select
    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = STEPS_FULL;
        w_dividend      = '0;
        w_divisor       = '0;
        unique case (r_state)
            ST_RECIP: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = STEPS_RECIP;
                w_dividend      = {RECIP_NUMERATOR, {(DVD_W-10){1'b0}}};
                w_divisor       = {{(DSR_W-10){1'b0}}, w_eff_win};
            end
            ST_AVG: begin
                w_div_ctl.start = 1'b1;
                w_dividend      = r_win_sum[31] ? (32'd0 - r_win_sum) : r_win_sum;
                w_divisor       = {{(DSR_W-10){1'b0}}, r_count};
            end
            ST_CDIV: begin
                w_div_ctl.start = 1'b1;
                w_dividend      = r_charge[31] ? (32'd0 - r_charge) : r_charge;
                w_divisor       = r_scale;
            end
            ST_IDLE, ST_ADD, ST_RECIPW, ST_AVGW, ST_CHG, ST_CDIVW, ST_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept && !i_clear_totals) n_state = ST_ADD;
            ST_ADD:    if (r_bit == 5'd31) n_state = r_due ? ST_RECIP : ST_IDLE;
            ST_RECIP:  n_state = ST_RECIPW;
            ST_RECIPW: if (w_div_stat.done) n_state = ST_AVG;
            ST_AVG:    n_state = ST_AVGW;
            ST_AVGW:   if (w_div_stat.done) n_state = ST_CHG;
            ST_CHG:    n_state = ST_CDIV;
            ST_CDIV:   n_state = ST_CDIVW;
            ST_CDIVW:  if (w_div_stat.done) n_state = ST_EMIT;
            ST_EMIT:   if (w_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_tpr       <= TPR_RESET;
            r_bias      <= BIAS_RESET;
            r_win_ticks <= '0;
            r_elapsed   <= '0;
            r_win_sum   <= '0;
            r_charge    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_TICKS_PER_REPORT: r_tpr  <= i_cfg_wdata;
                    CFG_SAMPLE_BIAS:      r_bias <= i_cfg_wdata[7:0];
                endcase
            end

            if (w_accept) begin
                if (i_clear_totals) begin
                    r_elapsed <= '0;
                    r_charge  <= '0;
                end else begin
                    r_elapsed   <= r_elapsed + 32'd1;
                    r_win_ticks <= w_next_due ? 10'd0 : w_next_ticks;
                end
            end

            // serial accumulate, lsb first
            if (r_state == ST_ADD) begin
                r_win_sum <= {w_bitsum[0], r_win_sum[31:1]};
            end else if (r_state == ST_AVG) begin
                r_win_sum <= '0;
            end

            if (r_state == ST_CHG) begin
                r_charge <= w_tot_sat;
            end

            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept && !i_clear_totals) begin
            r_ser_smp  <= i_current_sample;
            r_ser_bias <= r_bias;
            r_carry    <= 2'd0;
            r_bit      <= 5'd0;
            r_due      <= w_next_due;
            r_count    <= w_next_ticks;
        end else if (r_state == ST_ADD) begin
            r_ser_smp  <= {r_ser_smp[15], r_ser_smp[15:1]};
            r_ser_bias <= {r_ser_bias[7], r_ser_bias[7:1]};
            r_carry    <= w_bitsum[2:1];
            r_bit      <= r_bit + 5'd1;
        end

        if (r_state == ST_AVG) begin
            r_scale   <= w_quo[DSR_W-1:0] * CHARGE_SCALE;
            r_avg_neg <= r_win_sum[31];
        end

        if (r_state == ST_AVGW && w_div_stat.done) begin
            r_avg <= r_avg_neg ? (33'sd0 - $signed({1'b0, w_quo}))
                               : $signed({1'b0, w_quo});
        end

        if (r_state == ST_CDIV) begin
            r_chg_neg <= r_charge[31];
        end

        if (r_state == ST_EMIT && w_out_free) begin
            r_out_elapsed <= r_elapsed;
            r_out_avg     <= r_avg[16:0];
            r_out_chg     <= r_chg_neg ? (32'd0 - w_quo) : w_quo;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_elapsed_ms            = r_out_elapsed;
    assign o_average_current       = $signed(r_out_avg);
    assign o_charge_hundredths_mah = $signed(r_out_chg);

    `ASSERT_HOLDS(a_ticks_in_window,
        (w_accept && !i_clear_totals) |=> (r_win_ticks < $past(w_eff_win)),
        "window tick count reached window length")
    `ASSERT_NEVER(a_div_overlap,
        w_div_ctl.start && w_div_stat.busy,
        "divider launched while busy")
    `ASSERT_HOLDS(a_out_from_emit,
        $rose(o_out_valid) |-> $past(r_state == ST_EMIT),
        "result shown without emit")
    `ASSERT_NEVER(a_avg_zero_count,
        (r_state == ST_AVG) && (r_count == 10'd0),
        "average over zero samples")

endmodule

`default_nettype wire
